>>> rtl/huffman_tree_decoder_top_defines.svh
// Assertion macros used by the Huffman tree decoder checker.
`ifndef HUFFMAN_TREE_DECODER_TOP_DEFINES_SVH
`define HUFFMAN_TREE_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define HFD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hfd check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define HFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hfd check failed");

`endif

>>> rtl/hfd_pkg.sv
// Shared widths, command codes and status codes of the Huffman tree decoder.
`default_nettype none

package hfd_pkg;

  localparam int CMD_W  = 2;
  localparam int SYM_W  = 8;
  localparam int LEN_W  = 6;
  localparam int CODE_W = 32;
  localparam int BYTE_W = 8;
  localparam int VB_W   = 4;
  localparam int ST_W   = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

endpackage

`default_nettype wire

>>> rtl/hfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module hfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on request, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/huffman_tree_decoder_top.sv
// Huffman decoder walking a code tree held in a node memory, one code bit per step.
//
//   channel | valid    | stall     | payload
//   --------+----------+-----------+------------------------------------------------
//   in      | in_valid | in_stall  | cmd symbol code_length code_bits data_byte
//           |          |           | valid_bits
//   out     | out_valid| out_stall | out_symbol status last
//
// A data byte is walked bit by bit in S_WALK, a leaf whose next bit misses taking a
// step of its own; each bit is one dependent read of the node memory, and the final
// result leaves from S_FIN. A load visits S_LSTEP per code bit and S_LWAIT per node
// it follows. Clear and unused commands stay in S_IDLE. Reset clears the root and the
// walk position and sets the node count to one; a load writes a node's entry as it
// leaves it. A stalled output holds the walk only when a further result must leave.
`default_nettype none

module huffman_tree_decoder_top #(
  parameter int SYMBOL_COUNT  = 256,
  parameter int MAX_CODE_BITS = 32,
  parameter int NODE_SLOTS    = 512
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [hfd_pkg::CMD_W-1:0]   cmd,
  input  logic [hfd_pkg::SYM_W-1:0]   symbol,
  input  logic [hfd_pkg::LEN_W-1:0]   code_length,
  input  logic [hfd_pkg::CODE_W-1:0]  code_bits,
  input  logic [hfd_pkg::BYTE_W-1:0]  data_byte,
  input  logic [hfd_pkg::VB_W-1:0]    valid_bits,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [hfd_pkg::SYM_W-1:0]   out_symbol,
  output logic [hfd_pkg::ST_W-1:0]    status,
  output logic                        last
);

  import hfd_pkg::*;

  localparam int NW  = $clog2(NODE_SLOTS);
  localparam int UW  = NW + 1;
  localparam int LW1 = LEN_W + 1;
  localparam int SW1 = SYM_W + 1;
  localparam int CIW = $clog2(CODE_W);

  localparam logic [UW-1:0]    SLOTS  = UW'(NODE_SLOTS);
  localparam logic [LW1-1:0]   MAXLEN = LW1'(MAX_CODE_BITS);
  localparam logic [SW1-1:0]   SYMCNT = SW1'(SYMBOL_COUNT);
  localparam logic [VB_W-1:0]  VB_MAX = VB_W'(BYTE_W);
  localparam logic [LEN_W-1:0] CODE_N = LEN_W'(CODE_W);

  typedef struct packed {
    logic             leaf;
    logic [SYM_W-1:0] sym;
    logic [NW-1:0]    c1;
    logic [NW-1:0]    c0;
  } node_t;

  localparam int EW = $bits(node_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_LSTEP,
    S_LWAIT,
    S_FIN
  } state_t;

  state_t           state;
  node_t            root_q;
  node_t            cur;
  logic [NW-1:0]    pos;
  logic             pend;
  logic             chk;
  logic [NW-1:0]    pend_node;
  logic [NW-1:0]    node;
  logic [UW-1:0]    nodes_used;
  logic [LEN_W-1:0] cnt;
  logic [BYTE_W-1:0] sh;
  logic [CODE_W-1:0] code_q;
  logic [SYM_W-1:0] sym_q;
  logic             hold_valid;
  logic [SYM_W-1:0] hold_sym;
  status_t          hold_st;

  logic             ram_we;
  logic [NW-1:0]    ram_raddr;
  node_t            ram_wdata;
  logic [EW-1:0]    ram_rdata;
  node_t            rd;

  logic             out_free;
  logic             out_load;
  logic             hit;
  node_t            wcur;
  logic [NW-1:0]    wpos;
  logic             wbit;
  logic [NW-1:0]    wchild;
  logic             miss;
  logic             step;
  logic             emit;
  logic [SYM_W-1:0] e_sym;
  status_t          e_st;
  logic             wgo;
  logic             wdone;

  logic [LEN_W-1:0] lidx;
  logic             lbit;
  logic [NW-1:0]    lchild;
  logic             full;
  node_t            lupd;
  node_t            lleaf;
  logic             bad_load;
  logic [VB_W-1:0]  vb;

  hfd_ram #(
    .WIDTH (EW),
    .DEPTH (NODE_SLOTS)
  ) u_nodes (
    .clk   (clk),
    .we    (ram_we),
    .waddr (node),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd       = node_t'(ram_rdata);
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Walk step: settle the pending child, then take the next data bit
  always_comb begin
    hit    = pend && chk && rd.leaf;
    wcur   = !pend ? cur : (hit ? root_q : rd);
    wpos   = !pend ? pos : (hit ? '0 : pend_node);
    wbit   = sh[BYTE_W-1];
    wchild = wbit ? wcur.c1 : wcur.c0;
    miss   = (wchild == '0);
    // a leaf and a missing child in one cycle would make two results: split them
    step   = (cnt != '0) && !(hit && miss);
    emit   = hit || (step && miss);
    e_sym  = hit ? rd.sym : '0;
    e_st   = hit ? ST_OK : ST_INVALID;
    wgo    = !(emit && hold_valid && !out_free);
    wdone  = step ? (miss && (cnt == LEN_W'(1))) : (cnt == '0);
  end

  // Load the output register this cycle
  assign out_load = ((state == S_WALK) && wgo && emit && hold_valid) ||
                    ((state == S_FIN) && out_free);

  // Load step: pick the code bit and prepare node updates
  always_comb begin
    lidx   = cnt - LEN_W'(1);
    lbit   = (lidx < CODE_N) ? code_q[lidx[CIW-1:0]] : 1'b0;
    lchild = lbit ? cur.c1 : cur.c0;
    full   = (nodes_used >= SLOTS);
    lupd   = cur;
    if (lbit) begin
      lupd.c1 = nodes_used[NW-1:0];
    end else begin
      lupd.c0 = nodes_used[NW-1:0];
    end
    lleaf      = cur;
    lleaf.leaf = 1'b1;
    lleaf.sym  = sym_q;
  end

  // Node memory control
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = cur;
    ram_raddr = pos;
    unique case (state)
      S_WALK: begin
        ram_raddr = (wgo && step && !miss) ? wchild : pend_node;
      end
      S_LSTEP: begin
        ram_raddr = lchild;
        if (cnt == '0) begin
          ram_we    = 1'b1;
          ram_wdata = lleaf;
        end else if (lchild == '0) begin
          ram_we    = 1'b1;
          ram_wdata = full ? cur : lupd;
        end
      end
      default: begin
        ram_raddr = pos;
      end
    endcase
  end

  // Input checks
  assign bad_load = (code_length == '0) || ({1'b0, code_length} > MAXLEN) ||
                    ({1'b0, symbol} >= SYMCNT);
  assign vb = (valid_bits > VB_MAX) ? VB_MAX : valid_bits;

  // Sequencer, tree state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      root_q     <= '0;
      pos        <= '0;
      nodes_used <= UW'(1);
      pend       <= 1'b0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // drop a taken result
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      // mirror writes to the root
      if (ram_we && (node == '0)) begin
        root_q <= ram_wdata;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            unique case (cmd)
              CMD_LOAD: begin
                if (bad_load) begin
                  hold_sym   <= '0;
                  hold_st    <= ST_INVALID;
                  hold_valid <= 1'b1;
                  state      <= S_FIN;
                end else begin
                  cur    <= root_q;
                  node   <= '0;
                  cnt    <= code_length;
                  code_q <= code_bits;
                  sym_q  <= symbol;
                  state  <= S_LSTEP;
                end
              end
              CMD_DATA: begin
                if (valid_bits != '0) begin
                  sh        <= data_byte;
                  cnt       <= LEN_W'(vb);
                  // refetch the current node unless the walk sits at the root
                  pend      <= (pos != '0);
                  chk       <= 1'b0;
                  pend_node <= pos;
                  cur       <= root_q;
                  state     <= S_WALK;
                end
              end
              CMD_CLEAR: begin
                root_q     <= '0;
                nodes_used <= UW'(1);
                pos        <= '0;
              end
              default: begin
              end
            endcase
          end
        end

        S_WALK: begin
          if (wgo) begin
            // pass the earlier result on, keep the newest until the end is known
            if (emit) begin
              if (hold_valid) begin
                out_valid  <= 1'b1;
                out_symbol <= hold_sym;
                status     <= hold_st;
                last       <= 1'b0;
              end
              hold_sym   <= e_sym;
              hold_st    <= e_st;
              hold_valid <= 1'b1;
            end
            if (step) begin
              sh  <= sh << 1;
              cnt <= cnt - LEN_W'(1);
              if (miss) begin
                pos  <= '0;
                cur  <= root_q;
                pend <= 1'b0;
              end else begin
                pos       <= wpos;
                cur       <= wcur;
                pend      <= 1'b1;
                chk       <= 1'b1;
                pend_node <= wchild;
              end
            end else begin
              pos  <= wpos;
              cur  <= wcur;
              pend <= 1'b0;
            end
            if (wdone) begin
              state <= (hold_valid || emit) ? S_FIN : S_IDLE;
            end
          end
        end

        S_LSTEP: begin
          if (cnt == '0) begin
            hold_sym   <= sym_q;
            hold_st    <= ST_OK;
            hold_valid <= 1'b1;
            state      <= S_FIN;
          end else if (lchild != '0) begin
            node  <= lchild;
            cnt   <= cnt - LEN_W'(1);
            state <= S_LWAIT;
          end else if (full) begin
            hold_sym   <= '0;
            hold_st    <= ST_FULL;
            hold_valid <= 1'b1;
            state      <= S_FIN;
          end else begin
            // allocate a fresh node; its entry is written when the load leaves it
            cur        <= '0;
            node       <= nodes_used[NW-1:0];
            nodes_used <= nodes_used + UW'(1);
            cnt        <= cnt - LEN_W'(1);
          end
        end

        S_LWAIT: begin
          cur   <= rd;
          state <= S_LSTEP;
        end

        S_FIN: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_symbol <= hold_sym;
            status     <= hold_st;
            last       <= 1'b1;
            hold_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/hfd_checker.sv
// Port-level checker for the Huffman tree decoder and its bind to the top level.
`default_nettype none

`include "huffman_tree_decoder_top_defines.svh"

module hfd_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic [hfd_pkg::CMD_W-1:0]  cmd,
  input logic [hfd_pkg::VB_W-1:0]   valid_bits,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [hfd_pkg::SYM_W-1:0]  out_symbol,
  input logic [hfd_pkg::ST_W-1:0]   status,
  input logic                       last
);

  import hfd_pkg::*;

  // Error results carry a zero symbol
  `HFD_ASSERT_NOW(a_err_sym_zero, out_valid && (status != ST_OK), out_symbol == '0)

  // A stalled result holds
  `HFD_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(out_symbol) && $stable(status) && $stable(last))

  // Loads and nonempty data bytes keep the block busy
  `HFD_ASSERT_NEXT(a_work_busy,
                   in_valid && !in_stall && ((cmd == CMD_LOAD) ||
                   ((cmd == CMD_DATA) && (valid_bits != '0))), in_stall)

  // Clear completes without making the block busy
  `HFD_ASSERT_NEXT(a_clear_quick, in_valid && !in_stall && (cmd == CMD_CLEAR), !in_stall)

endmodule

bind huffman_tree_decoder_top hfd_checker u_hfd_checker (.*);

`default_nettype wire
